[rtl/core/assert_macros.svh]
// Assertion macros used by the port-level checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge, skipped while reset is held.
`define KDES_ASSERT_RST(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("keypad scanner check failed");

// Check a property on every rising edge, reset included.
`define KDES_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("keypad scanner check failed");

`endif

[rtl/core/kdes_pkg.sv]
// Shared types and constants of the keypad debounce event scanner.
package kdes_pkg;

  localparam int KEY_W        = 7;
  localparam int FIRST_W      = 6;
  localparam int SIZE_W       = 5;
  localparam int LINE_BITS    = 16;
  localparam int CODE_W       = 8;
  localparam int CNT_W        = 2;
  localparam int CODE_REGS    = 5;
  localparam int CFG_AW       = 6;
  localparam int CFG_DW       = 64;
  localparam int REG_IDX_W    = 3;
  localparam int NARROW_W     = 32;

  localparam logic [REG_IDX_W-1:0] REG_NARROW   = 3'd4;
  localparam logic [CNT_W-1:0]     PRESS_THRESH = 2'd2;
  localparam logic                 KIND_PRESS   = 1'b0;
  localparam logic                 KIND_RELEASE = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_FLUSH
  } scan_state_t;

  typedef struct packed {
    logic             flag;
    logic [CNT_W-1:0] cnt;
  } key_state_t;

  typedef struct packed {
    logic             rd_en;
    logic [KEY_W-1:0] rd_key;
    logic             wr_en;
    logic [KEY_W-1:0] wr_key;
    key_state_t       wr_data;
  } key_port_t;

endpackage

[rtl/core/kdes_code_regs.sv]
// APB register file of key report codes with a registered code lookup.
module kdes_code_regs
  import kdes_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready,
  input  key_port_t         kp,
  output logic [CODE_W-1:0] code_rdata
);

  logic [CFG_DW-1:0]    codes_r [CODE_REGS];
  logic [CODE_W-1:0]    code_r;
  logic [REG_IDX_W-1:0] reg_idx;
  logic                 wr_hit;
  logic [REG_IDX_W-1:0] lk_reg;
  logic [2:0]           lk_byte;

  assign reg_idx = paddr[CFG_AW-1:CFG_AW-REG_IDX_W];
  assign wr_hit  = psel & penable & pwrite & pready;
  assign pready  = 1'b1;
  assign lk_reg  = kp.rd_key[REG_IDX_W+2:3];
  assign lk_byte = kp.rd_key[2:0];

  always_comb begin
    prdata = '0;
    if (reg_idx < REG_IDX_W'(CODE_REGS)) begin
      prdata = codes_r[reg_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CODE_REGS; i++) begin
        codes_r[i] <= '0;
      end
    end else if (wr_hit && reg_idx < REG_IDX_W'(CODE_REGS)) begin
      if (reg_idx == REG_NARROW) begin
        codes_r[reg_idx] <= {{(CFG_DW-NARROW_W){1'b0}}, pwdata[NARROW_W-1:0]};
      end else begin
        codes_r[reg_idx] <= pwdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (kp.rd_en) begin
      code_r <= codes_r[lk_reg][{lk_byte, 3'b000} +: CODE_W];
    end
  end

  assign code_rdata = code_r;

endmodule

[rtl/core/kdes_key_mem.sv]
// Per-key debounce state memory with reset-cleared valid bits.
module kdes_key_mem
  import kdes_pkg::*;
#(
  parameter int DEPTH = 33,
  parameter int AW    = 6
) (
  input  logic       clk,
  input  logic       rst_n,
  input  key_port_t  kp,
  output key_state_t rdata
);

  key_state_t mem_r   [DEPTH];
  logic       valid_r [DEPTH];
  key_state_t rdata_r;
  logic [AW-1:0] raddr;
  logic [AW-1:0] waddr;

  assign raddr = kp.rd_key[AW-1:0];
  assign waddr = kp.wr_key[AW-1:0];

  always_ff @(posedge clk) begin
    if (kp.wr_en) begin
      mem_r[waddr] <= kp.wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < DEPTH; i++) begin
        valid_r[i] <= 1'b0;
      end
    end else if (kp.wr_en) begin
      valid_r[waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (kp.rd_en) begin
      rdata_r <= valid_r[raddr] ? mem_r[raddr] : '0;
    end
  end

  assign rdata = rdata_r;

endmodule

[rtl/core/kdes_scan_ctrl.sv]
// Scan sequencer: shifts the line word one key a cycle unless stalled, and builds events.
module kdes_scan_ctrl
  import kdes_pkg::*;
#(
  parameter int NUM_KEYS    = 33,
  parameter int GROUP_WIDTH = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [FIRST_W-1:0]   in_first_key,
  input  logic [SIZE_W-1:0]    in_group_size,
  input  logic [LINE_BITS-1:0] in_line_levels,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 out_event_kind,
  output logic [CODE_W-1:0]    out_key_code,
  output logic                 out_last_event,
  output key_port_t            kp,
  input  key_state_t           st_rdata,
  input  logic [CODE_W-1:0]    code_rdata
);

  localparam int GW_CAP = (GROUP_WIDTH < LINE_BITS) ? GROUP_WIDTH : LINE_BITS;

  scan_state_t          state_r, state_nxt;
  logic [KEY_W-1:0]     key_r, key_nxt;
  logic [LINE_BITS-1:0] lines_r, lines_nxt;
  logic [SIZE_W-1:0]    n_r, n_nxt;
  logic [SIZE_W-1:0]    idx_r, idx_nxt;
  logic                 s1_vld_r, s1_vld_nxt;
  logic                 s1_low_r, s1_low_nxt;
  logic                 s1_inr_r, s1_inr_nxt;
  logic [KEY_W-1:0]     s1_key_r, s1_key_nxt;
  logic                 pend_vld_r, pend_vld_nxt;
  logic                 pend_kind_r, pend_kind_nxt;
  logic [CODE_W-1:0]    pend_code_r, pend_code_nxt;
  logic                 out_vld_r, out_vld_nxt;
  logic                 out_kind_r, out_kind_nxt;
  logic [CODE_W-1:0]    out_code_r, out_code_nxt;
  logic                 out_last_r, out_last_nxt;

  key_state_t new_st;
  logic       ev_vld;
  logic       ev_kind;
  logic       ofree;
  logic       stall;

  always_comb begin
    new_st  = st_rdata;
    ev_vld  = 1'b0;
    ev_kind = KIND_PRESS;
    if (s1_vld_r && s1_inr_r) begin
      if (s1_low_r && !st_rdata.flag) begin
        new_st.cnt = CNT_W'(st_rdata.cnt + 1'b1);
        if (new_st.cnt == PRESS_THRESH) begin
          new_st.flag = 1'b1;
          ev_vld      = 1'b1;
          ev_kind     = KIND_PRESS;
        end
      end else if (!s1_low_r && st_rdata.flag) begin
        new_st  = '0;
        ev_vld  = 1'b1;
        ev_kind = KIND_RELEASE;
      end
    end
  end

  assign ofree = !out_vld_r || out_ready;
  assign stall = ev_vld && pend_vld_r && !ofree;

  always_comb begin
    state_nxt     = state_r;
    key_nxt       = key_r;
    lines_nxt     = lines_r;
    n_nxt         = n_r;
    idx_nxt       = idx_r;
    s1_vld_nxt    = s1_vld_r;
    s1_low_nxt    = s1_low_r;
    s1_inr_nxt    = s1_inr_r;
    s1_key_nxt    = s1_key_r;
    pend_vld_nxt  = pend_vld_r;
    pend_kind_nxt = pend_kind_r;
    pend_code_nxt = pend_code_r;
    out_vld_nxt   = out_vld_r && !out_ready;
    out_kind_nxt  = out_kind_r;
    out_code_nxt  = out_code_r;
    out_last_nxt  = out_last_r;
    in_ready      = 1'b0;
    kp            = '0;
    kp.rd_key     = key_r;
    kp.wr_key     = s1_key_r;
    kp.wr_data    = new_st;

    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          key_nxt   = {1'b0, in_first_key};
          lines_nxt = in_line_levels;
          n_nxt     = (in_group_size > SIZE_W'(GW_CAP)) ? SIZE_W'(GW_CAP) : in_group_size;
          idx_nxt   = '0;
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        if (!stall) begin
          s1_vld_nxt = 1'b0;
          if (idx_r < n_r) begin
            s1_vld_nxt = 1'b1;
            s1_low_nxt = !lines_r[0];
            s1_inr_nxt = key_r < KEY_W'(NUM_KEYS);
            s1_key_nxt = key_r;
            kp.rd_en   = key_r < KEY_W'(NUM_KEYS);
            key_nxt    = key_r + 1'b1;
            idx_nxt    = idx_r + 1'b1;
            lines_nxt  = lines_r >> 1;
          end
          if (s1_vld_r) begin
            kp.wr_en = s1_inr_r;
            if (ev_vld) begin
              if (pend_vld_r) begin
                out_vld_nxt  = 1'b1;
                out_kind_nxt = pend_kind_r;
                out_code_nxt = pend_code_r;
                out_last_nxt = 1'b0;
              end
              pend_vld_nxt  = 1'b1;
              pend_kind_nxt = ev_kind;
              pend_code_nxt = code_rdata;
            end
          end
        end
        if (idx_r == n_r && !s1_vld_r) begin
          state_nxt = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        if (!pend_vld_r) begin
          state_nxt = ST_IDLE;
        end else if (ofree) begin
          out_vld_nxt  = 1'b1;
          out_kind_nxt = pend_kind_r;
          out_code_nxt = pend_code_r;
          out_last_nxt = 1'b1;
          pend_vld_nxt = 1'b0;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      s1_vld_r   <= 1'b0;
      pend_vld_r <= 1'b0;
      out_vld_r  <= 1'b0;
      idx_r      <= '0;
      n_r        <= '0;
    end else begin
      state_r    <= state_nxt;
      s1_vld_r   <= s1_vld_nxt;
      pend_vld_r <= pend_vld_nxt;
      out_vld_r  <= out_vld_nxt;
      idx_r      <= idx_nxt;
      n_r        <= n_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r       <= key_nxt;
    lines_r     <= lines_nxt;
    s1_low_r    <= s1_low_nxt;
    s1_inr_r    <= s1_inr_nxt;
    s1_key_r    <= s1_key_nxt;
    pend_kind_r <= pend_kind_nxt;
    pend_code_r <= pend_code_nxt;
    out_kind_r  <= out_kind_nxt;
    out_code_r  <= out_code_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign out_valid      = out_vld_r;
  assign out_event_kind = out_kind_r;
  assign out_key_code   = out_code_r;
  assign out_last_event = out_last_r;

endmodule

[rtl/core/keypad_debounce_event_scanner_core.sv]
// Keypad debounce event scanner, top level.
//
// Input channel (in_valid/in_ready): one word is one scan of a key group:
// first key number, group size and the active-low line levels.
// Result channel (out_valid/out_ready): one word per press or release
// event, with the key's report code; last_event marks the scan's final one.
// APB port: five code registers at byte addresses 0, 8, 16, 24 and 32.
// Flow: a scan of n keys walks the line word one key per cycle, unless
// stalled, through the key state memory read port; the next scan is
// accepted only once this one has flushed and the scanner is idle again.
// An event is held until the next event of the scan appears, or until the
// scan ends, so that the last one can be marked.
// Reset: all keys released with cleared counters, all codes zero; no
// clearing pass is needed.
// Receiver stall: the output register and one held event absorb it; the
// scan then pauses on the next event until the output register frees.
module keypad_debounce_event_scanner_core
  import kdes_pkg::*;
#(
  parameter int NUM_KEYS    = 33,
  parameter int GROUP_WIDTH = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [FIRST_W-1:0]   in_first_key,
  input  logic [SIZE_W-1:0]    in_group_size,
  input  logic [LINE_BITS-1:0] in_line_levels,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 out_event_kind,
  output logic [CODE_W-1:0]    out_key_code,
  output logic                 out_last_event,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [CFG_AW-1:0]    paddr,
  input  logic [CFG_DW-1:0]    pwdata,
  output logic [CFG_DW-1:0]    prdata,
  output logic                 pready
);

  localparam int KEY_AW = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;

  key_port_t         kp;
  key_state_t        st_rdata;
  logic [CODE_W-1:0] code_rdata;

  kdes_scan_ctrl #(
    .NUM_KEYS    (NUM_KEYS),
    .GROUP_WIDTH (GROUP_WIDTH)
  ) u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_first_key   (in_first_key),
    .in_group_size  (in_group_size),
    .in_line_levels (in_line_levels),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_event_kind (out_event_kind),
    .out_key_code   (out_key_code),
    .out_last_event (out_last_event),
    .kp             (kp),
    .st_rdata       (st_rdata),
    .code_rdata     (code_rdata)
  );

  kdes_key_mem #(
    .DEPTH (NUM_KEYS),
    .AW    (KEY_AW)
  ) u_mem (
    .clk   (clk),
    .rst_n (rst_n),
    .kp    (kp),
    .rdata (st_rdata)
  );

  kdes_code_regs u_regs (
    .clk        (clk),
    .rst_n      (rst_n),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .kp         (kp),
    .code_rdata (code_rdata)
  );

endmodule

[rtl/core/kdes_checker.sv]
// Port-level checker for the keypad scanner and its bind.
`include "assert_macros.svh"

module kdes_checker
  import kdes_pkg::*;
(
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_valid,
  input logic                 in_ready,
  input logic [SIZE_W-1:0]    in_group_size,
  input logic                 out_valid,
  input logic                 out_ready,
  input logic                 out_event_kind,
  input logic [CODE_W-1:0]    out_key_code,
  input logic                 out_last_event,
  input logic                 pready
);

  `KDES_ASSERT_ALWAYS(a_pready_high, clk, pready)

  `KDES_ASSERT_RST(a_one_scan, clk, rst_n, in_valid && in_ready |=> !in_ready)

  `KDES_ASSERT_RST(a_empty_scan, clk, rst_n,
    in_valid && in_ready && in_group_size == '0 |-> ##3 in_ready)

  `KDES_ASSERT_RST(a_out_hold, clk, rst_n,
    out_valid && !out_ready |=> out_valid && $stable(out_event_kind) &&
    $stable(out_key_code) && $stable(out_last_event))

endmodule

bind keypad_debounce_event_scanner_core kdes_checker u_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_ready       (in_ready),
  .in_group_size  (in_group_size),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_event_kind (out_event_kind),
  .out_key_code   (out_key_code),
  .out_last_event (out_last_event),
  .pready         (pready)
);

[bench/testbench.sv]
// Self-checking bench for the keypad debounce event scanner core.
`timescale 1ns / 100ps

module testbench;
  import kdes_pkg::*;

  localparam int KEYS       = 33;
  localparam int GROUP_KEYS = 16;
  localparam int HOLD_OFF   = 40;

  localparam int REG_CODES_0_7   = 0;
  localparam int REG_CODES_8_15  = 1;
  localparam int REG_CODES_16_23 = 2;
  localparam int REG_CODES_24_31 = 3;
  localparam int REG_CODES_32_35 = 4;
  localparam int REG_UNMAPPED    = 5;

  typedef struct packed {
    logic [FIRST_W-1:0]   first;
    logic [SIZE_W-1:0]    size;
    logic [LINE_BITS-1:0] lines;
  } scan_word_t;

  typedef struct packed {
    logic              kind;
    logic [CODE_W-1:0] code;
    logic              last;
  } key_event_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [FIRST_W-1:0]   in_first_key = '0;
  logic [SIZE_W-1:0]    in_group_size = '0;
  logic [LINE_BITS-1:0] in_line_levels = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic                 out_event_kind;
  logic [CODE_W-1:0]    out_key_code;
  logic                 out_last_event;
  logic                 psel = 1'b0;
  logic                 penable = 1'b0;
  logic                 pwrite = 1'b0;
  logic [CFG_AW-1:0]    paddr = '0;
  logic [CFG_DW-1:0]    pwdata = '0;
  logic [CFG_DW-1:0]    prdata;
  logic                 pready;

  scan_word_t           scan_fifo[$];
  key_event_t           pending_events[$];
  logic [63:0]          code_bank[CODE_REGS];
  logic                 key_down[KEYS];
  logic [CNT_W-1:0]     press_cnt[KEYS];
  logic                 scan_taken = 1'b0;
  bit                   idle_en = 1'b1;
  int                   send_gap = 0;
  int                   recv_stall = 0;
  int                   mismatch_count = 0;
  logic [FIRST_W-1:0]   grp_first = '0;
  logic [SIZE_W-1:0]    grp_size = 5'd16;
  logic [LINE_BITS-1:0] grp_lines = '1;

  keypad_debounce_event_scanner_core #(
    .NUM_KEYS   (KEYS),
    .GROUP_WIDTH(GROUP_KEYS)
  ) u_top (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_first_key  (in_first_key),
    .in_group_size (in_group_size),
    .in_line_levels(in_line_levels),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_event_kind(out_event_kind),
    .out_key_code  (out_key_code),
    .out_last_event(out_last_event),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always #4 clk = ~clk;

  function automatic logic [CODE_W-1:0] code_of_key(input int key);
    int bank;
    bank = key >> 3;
    if (bank >= CODE_REGS) return '0;
    return code_bank[bank][(key & 7) * 8 +: 8];
  endfunction

  task automatic apply_scan(input scan_word_t w);
    key_event_t evs[GROUP_KEYS];
    key_event_t ev;
    int n;
    int cnt;
    int key;
    bit hit;
    n = (w.size > GROUP_KEYS) ? GROUP_KEYS : int'(w.size);
    cnt = 0;
    for (int k = 0; k < n; k++) begin
      key = int'(w.first) + k;
      hit = 1'b0;
      if (key >= KEYS) continue;
      if (!w.lines[k]) begin
        if (!key_down[key]) begin
          press_cnt[key] = press_cnt[key] + 1'b1;
          if (press_cnt[key] == PRESS_THRESH) begin
            key_down[key] = 1'b1;
            ev.kind = KIND_PRESS;
            hit = 1'b1;
          end
        end
      end else if (key_down[key]) begin
        key_down[key] = 1'b0;
        press_cnt[key] = '0;
        ev.kind = KIND_RELEASE;
        hit = 1'b1;
      end
      if (hit) begin
        ev.code = code_of_key(key);
        ev.last = 1'b0;
        evs[cnt] = ev;
        cnt++;
      end
    end
    for (int j = 0; j < cnt; j++) begin
      ev = evs[j];
      ev.last = (j == cnt - 1);
      pending_events.push_back(ev);
    end
  endtask

  // drive scan words
  always @(negedge clk) begin
    scan_word_t w;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || scan_taken) begin
      if (send_gap == 0 && idle_en && $urandom_range(0, 4) == 0)
        send_gap = $urandom_range(1, 8);
      if (send_gap > 0) begin
        send_gap--;
        in_valid <= 1'b0;
      end else if (scan_fifo.size() != 0) begin
        w = scan_fifo.pop_front();
        in_first_key   <= w.first;
        in_group_size  <= w.size;
        in_line_levels <= w.lines;
        in_valid       <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // stall the result side
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (recv_stall > 0) begin
      recv_stall--;
      out_ready <= 1'b0;
    end else if (idle_en && $urandom_range(0, 4) == 0) begin
      recv_stall = $urandom_range(0, 7);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // check events, then predict from accepted scans
  always @(posedge clk) begin
    key_event_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_events.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected event: kind %0d code %02h last %0d",
                   out_event_kind, out_key_code, out_last_event);
      end else begin
        want = pending_events.pop_front();
        if (out_event_kind !== want.kind || out_key_code !== want.code ||
            out_last_event !== want.last) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("event mismatch: expected kind %0d code %02h last %0d, got kind %0d code %02h last %0d",
                     want.kind, want.code, want.last,
                     out_event_kind, out_key_code, out_last_event);
        end
      end
    end
    if (rst_n && in_valid && in_ready)
      apply_scan({in_first_key, in_group_size, in_line_levels});
    scan_taken <= rst_n && in_valid && in_ready;
  end

  task automatic cfg_write(input int idx, input logic [63:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CFG_AW'(idx * 8);
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (idx < CODE_REGS)
      code_bank[idx] = (idx == REG_NARROW) ? {32'h0, value[31:0]} : value;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic load_codes(input logic [63:0] v0, input logic [63:0] v1,
                            input logic [63:0] v2, input logic [63:0] v3,
                            input logic [63:0] v4);
    cfg_write(REG_CODES_0_7, v0);
    cfg_write(REG_CODES_8_15, v1);
    cfg_write(REG_CODES_16_23, v2);
    cfg_write(REG_CODES_24_31, v3);
    cfg_write(REG_CODES_32_35, v4);
  endtask

  task automatic add_scan(input int first, input int size, input logic [15:0] lines);
    scan_fifo.push_back({FIRST_W'(first), SIZE_W'(size), lines});
  endtask

  task automatic settle();
    do @(posedge clk);
    while (scan_fifo.size() != 0 || in_valid || pending_events.size() != 0);
    repeat (HOLD_OFF) @(posedge clk);
  endtask

  // mostly repeat scans of one group with sparse line flips, plus new groups and noise
  task automatic add_random_scans(input int count);
    int pick;
    logic [31:0] flips;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        flips = $urandom & $urandom & $urandom;
        grp_lines = grp_lines ^ flips[15:0];
        add_scan(grp_first, grp_size, grp_lines);
      end else if (pick < 90) begin
        grp_first = FIRST_W'($urandom_range(0, 32));
        grp_size  = SIZE_W'($urandom_range(1, 16));
        case ($urandom_range(0, 9))
          0:       grp_lines = '0;
          1:       grp_lines = '1;
          default: grp_lines = LINE_BITS'($urandom);
        endcase
        add_scan(grp_first, grp_size, grp_lines);
      end else begin
        add_scan($urandom_range(0, 63), $urandom_range(0, 31), LINE_BITS'($urandom));
      end
    end
  endtask

  initial begin
    #5_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    for (int r = 0; r < CODE_REGS; r++) code_bank[r] = '0;
    for (int k = 0; k < KEYS; k++) begin
      key_down[k]  = 1'b0;
      press_cnt[k] = '0;
    end
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    load_codes({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
               {$urandom, $urandom}, {$urandom, $urandom});
    cfg_write(REG_UNMAPPED, {$urandom, $urandom});

    add_scan(0, 16, 16'h0000);
    add_scan(0, 16, 16'h0000);
    add_scan(0, 16, 16'hFFFF);
    add_scan(16, 16, 16'h0000);
    add_scan(16, 16, 16'h0000);
    add_scan(32, 16, 16'h0000);
    add_scan(32, 1, 16'h0000);
    add_scan(32, 16, 16'hFFFF);
    add_scan(5, 0, 16'h0000);
    add_scan(0, 31, 16'h0000);
    add_scan(0, 17, 16'h0000);
    add_scan(0, 16, 16'hFFFF);
    add_scan(16, 16, 16'hFFFF);
    add_scan(20, 1, 16'h0000);
    add_scan(20, 1, 16'hFFFF);
    add_scan(20, 1, 16'hFFFE);
    add_scan(63, 16, 16'h0000);
    add_scan(8, 16, 16'h5555);
    add_scan(8, 16, 16'h5555);
    add_scan(8, 16, 16'hAAAA);
    add_scan(8, 16, 16'hAAAA);
    add_scan(8, 16, 16'hFFFF);
    settle();

    load_codes('1, '1, '1, '1, '1);
    add_random_scans(100);
    settle();

    load_codes('0, '0, '0, '0, '0);
    add_random_scans(40);
    settle();

    load_codes({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
               {$urandom, $urandom}, {$urandom, $urandom});
    add_random_scans(160);
    settle();

    load_codes({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
               {$urandom, $urandom}, {$urandom, $urandom});
    idle_en = 1'b0;
    add_random_scans(100);
    settle();

    if (mismatch_count == 0 && pending_events.size() == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule
